[design/pfat_pkg.sv]
// Package with the shared types and constants of the paged frame allocator.
package pfat_pkg;

    localparam int NUM_FRAMES_DEF    = 16;
    localparam int MAX_JOBS_DEF      = 16;
    localparam int MAX_PAGE_SIZE_DEF = 4096;

    localparam logic [12:0] PAGE_SIZE_RST = 13'd512;
    localparam logic [4:0]  FRAMES_RST    = 5'd10;
    localparam logic [15:0] SEED_RST      = 16'd1;
    localparam logic [15:0] LFSR_MASK     = 16'hB400;

    typedef enum logic [1:0] {
        ACT_CLEAR     = 2'd0,
        ACT_ALLOCATE  = 2'd1,
        ACT_TRANSLATE = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOFRAMES  = 3'd1,
        ST_OOB       = 3'd2,
        ST_NOTLOADED = 3'd3,
        ST_LOADED    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_PAGE_SIZE = 2'd0,
        REG_FRAMES    = 2'd1,
        REG_SEED      = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  job_slot;
        logic [15:0] job_size;
        logic [15:0] logical_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] page_number;
        logic [3:0]  frame_number;
        logic [11:0] page_offset;
        logic [15:0] physical_address;
        logic [11:0] fragmentation;
        logic [15:0] page_count;
        logic        last;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DECIDE,
        S_PICK,
        S_SEARCH,
        S_MUL,
        S_EMIT,
        S_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic div_step;
        logic decide;
        logic pick;
        logic search;
        logic mul;
        logic emit;
        logic next_page;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic multi;
        logic found;
        logic last_page;
        logic out_busy;
        logic place;
    } sts_t;

endpackage

[design/pfat_ctrl.sv]
// Controller state machine of the paged frame allocator.
module pfat_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pfat_pkg::sts_t    sts,
    output pfat_pkg::cmd_t    cmd
);

    pfat_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfat_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pfat_pkg::S_IDLE: begin
                if (s_valid) state_next = pfat_pkg::S_DIV;
            end
            pfat_pkg::S_DIV: begin
                if (sts.div_done) state_next = pfat_pkg::S_DECIDE;
            end
            pfat_pkg::S_DECIDE: begin
                if (sts.place) state_next = pfat_pkg::S_PICK;
                else state_next = pfat_pkg::S_MUL;
            end
            pfat_pkg::S_PICK: state_next = pfat_pkg::S_SEARCH;
            pfat_pkg::S_SEARCH: begin
                if (sts.found) state_next = pfat_pkg::S_MUL;
            end
            pfat_pkg::S_MUL: state_next = pfat_pkg::S_EMIT;
            pfat_pkg::S_EMIT: begin
                if (!sts.out_busy) state_next = pfat_pkg::S_WAIT;
            end
            pfat_pkg::S_WAIT: begin
                if (sts.multi && !sts.last_page) state_next = pfat_pkg::S_PICK;
                else state_next = pfat_pkg::S_IDLE;
            end
            default: state_next = pfat_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            pfat_pkg::S_IDLE: begin
                s_ready = 1'b1;
                cmd.take = s_valid;
            end
            pfat_pkg::S_DIV:    cmd.div_step = 1'b1;
            pfat_pkg::S_DECIDE: cmd.decide = 1'b1;
            pfat_pkg::S_PICK:   cmd.pick = 1'b1;
            pfat_pkg::S_SEARCH: cmd.search = 1'b1;
            pfat_pkg::S_MUL:    cmd.mul = 1'b1;
            pfat_pkg::S_EMIT:   cmd.emit = !sts.out_busy;
            pfat_pkg::S_WAIT:   cmd.next_page = sts.multi && !sts.last_page;
            default: ;
        endcase
    end

endmodule

[design/pfat_datapath.sv]
// Datapath of the paged frame allocator: divider, tables, frame search and output register.
module pfat_datapath #(
    parameter int NUM_FRAMES    = pfat_pkg::NUM_FRAMES_DEF,
    parameter int MAX_JOBS      = pfat_pkg::MAX_JOBS_DEF,
    parameter int MAX_PAGE_SIZE = pfat_pkg::MAX_PAGE_SIZE_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_index,
    input  logic [15:0]      cfg_data,
    input  pfat_pkg::req_t   s_data,
    output pfat_pkg::rsp_t   m_data,
    output logic             m_valid,
    input  logic             m_ready,
    input  pfat_pkg::cmd_t   cmd,
    output pfat_pkg::sts_t   sts
);

    localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int FCW   = $clog2(NUM_FRAMES + 1);
    localparam int JW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int PTD   = MAX_JOBS * NUM_FRAMES;
    localparam int PTW   = (PTD > 1) ? $clog2(PTD) : 1;

    logic [12:0] page_size_reg;
    logic [4:0]  frames_reg;
    logic [15:0] seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_size_reg <= pfat_pkg::PAGE_SIZE_RST;
            frames_reg    <= pfat_pkg::FRAMES_RST;
            seed_reg      <= pfat_pkg::SEED_RST;
        end else if (cfg_we) begin
            if (cfg_index == 16'(pfat_pkg::REG_PAGE_SIZE)) page_size_reg <= cfg_data[12:0];
            if (cfg_index == 16'(pfat_pkg::REG_FRAMES))    frames_reg    <= cfg_data[4:0];
            if (cfg_index == 16'(pfat_pkg::REG_SEED))      seed_reg      <= cfg_data;
        end
    end

    logic [16:0] ps_eff;
    logic [6:0]  lim;
    always_comb begin
        if (page_size_reg == 13'd0) ps_eff = 17'd1;
        else if (32'(page_size_reg) > MAX_PAGE_SIZE) ps_eff = 17'(MAX_PAGE_SIZE);
        else ps_eff = 17'(page_size_reg);
        if (frames_reg == 5'd0) lim = 7'd1;
        else if (32'(frames_reg) > NUM_FRAMES) lim = 7'(NUM_FRAMES);
        else lim = 7'(frames_reg);
    end

    pfat_pkg::req_t req_reg;
    logic [16:0] ps_reg;

    logic [15:0] quo_reg;
    logic [16:0] rem_reg;
    logic [4:0]  div_cnt_reg;

    logic [NUM_FRAMES-1:0] frame_free_reg;
    logic [16:0]           job_pages_reg [MAX_JOBS];
    logic [MAX_JOBS-1:0]   job_loaded_reg;
    logic [FW-1:0]         pt_mem [PTD];
    logic [15:0]           lfsr_reg;

    logic [16:0] cnt_reg;
    logic        multi_reg;
    logic [15:0] page_reg;
    logic [FW-1:0] cur_reg;
    logic [4:0]  mod_rem_reg;
    logic [4:0]  mod_cnt_reg;
    logic [FW-1:0] ptrd_reg;
    pfat_pkg::rsp_t res_reg;
    logic [15:0] prod;

    logic [16:0] rem_shift;
    logic [15:0] dividend;
    assign dividend  = (req_reg.action == pfat_pkg::ACT_TRANSLATE) ?
                       req_reg.logical_address : req_reg.job_size;
    assign rem_shift = {rem_reg[15:0], dividend[4'd15 - div_cnt_reg[3:0]]};

    logic [FCW-1:0] freec;
    always_comb begin
        freec = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (frame_free_reg[i] && (i < 32'(lim))) freec = freec + FCW'(1);
        end
    end

    logic [15:0] lfsr_stepped;
    assign lfsr_stepped = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ pfat_pkg::LFSR_MASK) : (lfsr_reg >> 1);

    logic [JW-1:0] slot;
    logic          slot_ok;
    assign slot    = JW'(req_reg.job_slot);
    assign slot_ok = 32'(req_reg.job_slot) < MAX_JOBS;

    logic [PTW-1:0] pt_addr;
    assign pt_addr = PTW'(32'(slot) * NUM_FRAMES
                     + 32'((req_reg.action == pfat_pkg::ACT_TRANSLATE) ? quo_reg : page_reg));

    // The LFSR value is reduced modulo the frame limit one bit per cycle.
    logic [5:0] mod_shift;
    logic [5:0] mod_step;
    logic       mod_done;
    assign mod_shift = {mod_rem_reg, lfsr_reg[4'd15 - mod_cnt_reg[3:0]]};
    assign mod_step  = (7'(mod_shift) >= lim) ? 6'(7'(mod_shift) - lim) : mod_shift;
    assign mod_done  = (mod_cnt_reg == 5'd16);

    logic [16:0] cnt_calc;
    logic [11:0] frag_calc;
    assign cnt_calc  = 17'(quo_reg) + ((rem_reg != 17'd0) ? 17'd1 : 17'd0);
    assign frag_calc = (rem_reg != 17'd0) ? 12'(ps_reg - rem_reg) : 12'd0;

    logic place;
    logic last_page;
    logic xlat_ok;
    assign place = (req_reg.action == pfat_pkg::ACT_ALLOCATE) && slot_ok &&
                   !job_loaded_reg[slot] && (cnt_calc != 17'd0) &&
                   (cnt_calc <= 17'(freec));
    assign last_page = (17'(page_reg) + 17'd1) == cnt_reg;
    assign xlat_ok   = (req_reg.action == pfat_pkg::ACT_TRANSLATE) &&
                       (res_reg.status == pfat_pkg::ST_OK);

    assign sts.div_done  = (div_cnt_reg == 5'd16);
    assign sts.found     = mod_done && frame_free_reg[cur_reg];
    assign sts.multi     = multi_reg;
    assign sts.last_page = last_page;
    assign sts.out_busy  = m_valid && !m_ready;
    assign sts.place     = place;

    pfat_pkg::rsp_t dec_res;
    always_comb begin
        dec_res = '0;
        dec_res.last = 1'b1;
        case (req_reg.action)
            pfat_pkg::ACT_ALLOCATE: begin
                dec_res.fragmentation = frag_calc;
                dec_res.page_count    = 16'(cnt_calc);
                if (!slot_ok) begin
                    dec_res.status = pfat_pkg::ST_OOB;
                end else if (job_loaded_reg[slot]) begin
                    dec_res.status = pfat_pkg::ST_LOADED;
                end else if (cnt_calc > 17'(freec)) begin
                    dec_res.status = pfat_pkg::ST_NOFRAMES;
                end else begin
                    dec_res.status = pfat_pkg::ST_OK;
                end
            end
            pfat_pkg::ACT_TRANSLATE: begin
                dec_res.page_number = quo_reg;
                dec_res.page_offset = 12'(rem_reg);
                if (!slot_ok) begin
                    dec_res.status = pfat_pkg::ST_OOB;
                end else begin
                    dec_res.page_count = 16'(job_pages_reg[slot]);
                    if (17'(quo_reg) >= job_pages_reg[slot]) begin
                        dec_res.status = pfat_pkg::ST_OOB;
                    end else if (!job_loaded_reg[slot]) begin
                        dec_res.status = pfat_pkg::ST_NOTLOADED;
                    end else begin
                        dec_res.status = pfat_pkg::ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    pfat_pkg::rsp_t emit_data;
    always_comb begin
        emit_data = res_reg;
        emit_data.physical_address = prod;
        if (multi_reg) begin
            emit_data.page_number  = page_reg;
            emit_data.frame_number = 4'(cur_reg);
            emit_data.last         = last_page;
        end else if (xlat_ok) begin
            emit_data.frame_number = 4'(ptrd_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_free_reg <= '1;
            job_loaded_reg <= '0;
            for (int j = 0; j < MAX_JOBS; j++) job_pages_reg[j] <= '0;
            lfsr_reg    <= pfat_pkg::SEED_RST;
            m_valid     <= 1'b0;
            multi_reg   <= 1'b0;
            div_cnt_reg <= '0;
            mod_cnt_reg <= '0;
        end else begin
            if (cmd.emit) begin
                m_valid <= req_reg.action inside {pfat_pkg::ACT_CLEAR, pfat_pkg::ACT_ALLOCATE,
                                                  pfat_pkg::ACT_TRANSLATE};
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
            if (cmd.take) begin
                req_reg     <= s_data;
                ps_reg      <= ps_eff;
                quo_reg     <= '0;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
                multi_reg   <= 1'b0;
                page_reg    <= '0;
            end
            if (cmd.div_step && div_cnt_reg != 5'd16) begin
                if (rem_shift >= ps_reg) begin
                    rem_reg <= rem_shift - ps_reg;
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
            if (cmd.decide) begin
                res_reg   <= dec_res;
                cnt_reg   <= cnt_calc;
                ptrd_reg  <= pt_mem[pt_addr];
                multi_reg <= place;
                if (req_reg.action == pfat_pkg::ACT_CLEAR) begin
                    frame_free_reg <= '1;
                    job_loaded_reg <= '0;
                    for (int j = 0; j < MAX_JOBS; j++) job_pages_reg[j] <= '0;
                    lfsr_reg <= (seed_reg == 16'd0) ? 16'd1 : seed_reg;
                end else if (req_reg.action == pfat_pkg::ACT_ALLOCATE && slot_ok &&
                             !job_loaded_reg[slot]) begin
                    job_pages_reg[slot] <= cnt_calc;
                    if (cnt_calc <= 17'(freec)) job_loaded_reg[slot] <= 1'b1;
                end
            end
            if (cmd.pick) begin
                lfsr_reg    <= lfsr_stepped;
                mod_rem_reg <= '0;
                mod_cnt_reg <= '0;
            end
            if (cmd.search) begin
                if (!mod_done) begin
                    mod_rem_reg <= mod_step[4:0];
                    mod_cnt_reg <= mod_cnt_reg + 5'd1;
                    cur_reg     <= FW'(mod_step);
                end else if (!frame_free_reg[cur_reg]) begin
                    cur_reg <= (7'(cur_reg) + 7'd1 == lim) ? '0 : cur_reg + FW'(1);
                end
            end
            if (cmd.mul) begin
                if (multi_reg) begin
                    frame_free_reg[cur_reg] <= 1'b0;
                    pt_mem[pt_addr] <= cur_reg;
                    prod <= 16'(32'(cur_reg) * 32'(ps_reg));
                end else if (xlat_ok) begin
                    prod <= 16'(32'(ptrd_reg) * 32'(ps_reg) + 32'(rem_reg));
                end else begin
                    prod <= '0;
                end
            end
            if (cmd.emit) m_data <= emit_data;
            if (cmd.next_page) page_reg <= page_reg + 16'd1;
        end
    end

endmodule

[design/paged_frame_allocator_translator.sv]
// Top level of the paged frame allocator with address translation.
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    pfat_pkg::req_t
//   m_       out        m_valid/m_ready    pfat_pkg::rsp_t
// A request with one result passes through the divider, then decide, multiply, emit and
// wait, and the next request is taken once the block is back in idle.
// An allocation of n pages runs the divider and decide, then per page an LFSR step, a
// modulo reduction, one free-frame check plus a further check per occupied frame passed over,
// multiply, emit and wait. Reset is synchronous, active low, and restores the
// configuration and an empty frame table. A stalled result holds the block in emit.
module paged_frame_allocator_translator #(
    parameter int NUM_FRAMES    = pfat_pkg::NUM_FRAMES_DEF,
    parameter int MAX_JOBS      = pfat_pkg::MAX_JOBS_DEF,
    parameter int MAX_PAGE_SIZE = pfat_pkg::MAX_PAGE_SIZE_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  pfat_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pfat_pkg::rsp_t  m_data
);

    pfat_pkg::cmd_t cmd;
    pfat_pkg::sts_t sts;

    pfat_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .sts(sts), .cmd(cmd)
    );

    pfat_datapath #(
        .NUM_FRAMES(NUM_FRAMES), .MAX_JOBS(MAX_JOBS), .MAX_PAGE_SIZE(MAX_PAGE_SIZE)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_data(s_data), .m_data(m_data), .m_valid(m_valid),
        .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

`ifndef SYNTHESIS
    a_take_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> s_ready) else $error("request taken while busy");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !(m_valid && !m_ready)) else $error("result overwritten");
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd)) else $error("conflicting commands");
`endif

endmodule
